// File: sv/assert_macros.svh
// Assertion macros shared by the digit selector RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define MDSS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define MDSS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define MDSS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MDSS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/mdss_pkg.sv
// Package for the max digit subsequence select block: word types, defaults,
// controller states and the command/status bundles. No dependencies.
package mdss_pkg;

	// Defaults for the top-level parameters
	localparam int DEQUE_DEPTH_DEF   = 256;
	localparam int POSITION_BITS_DEF = 16;

	// Fixed field widths
	localparam int DIGIT_W     = 4;
	localparam int DELETIONS_W = 8;

	// Configuration port
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_IDX_DELETIONS = 1'b0;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} in_word_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] kept_digit;
		logic               final_res;
	} out_word_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_BACK_WAIT,
		S_EMIT
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic accept;
		logic drop_back;
		logic load_back;
		logic push;
		logic emit;
		logic finish;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic back_lt;
		logic emit_hit;
		logic out_free;
	} status_t;

endpackage

// File: sv/max_digit_subsequence_select_unit.sv
// Max digit subsequence select: keeps the digits that form the largest number
// after deleting a configured count from each string.
// Input channel (in_valid/in_stall/in_word): one decimal digit per word, with
// last marking the end of a string. Output channel (out_valid/out_stall/
// out_word): the kept digits in order, final_res on the last one.
// The deletions register (APB, address 0) is latched at a string's first digit.
// Sequence: a digit that pops nothing and emits nothing passes IDLE and SCAN;
// each entry popped from the back of the deque adds a pass through BACK_WAIT
// (pop, then a RAM read of the new back); an emitted digit adds the EMIT state.
// Pops are bounded by pushes. When no pops occur, the output word is registered
// from the EMIT state that follows SCAN.
// The single-read-port deque RAM sets this sequence.
// A finished word waits in the output register; further digits are still taken
// until one needs to emit, which then holds off input until out_stall drops.
// Reset empties the deque and clears deletions to zero; no clearing pass.
// Depends on mdss_pkg, mdss_ctrl, mdss_dp and mdss_ram.
module max_digit_subsequence_select_unit #(
	parameter int DEQUE_DEPTH   = mdss_pkg::DEQUE_DEPTH_DEF,
	parameter int POSITION_BITS = mdss_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// digit input
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mdss_pkg::in_word_t              in_word,
	// kept digit output
	output logic                            out_valid,
	input  logic                            out_stall,
	output mdss_pkg::out_word_t             out_word,
	// configuration
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mdss_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [mdss_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [mdss_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);

	logic [mdss_pkg::DELETIONS_W-1:0] deletions_q;
	logic                             reg_hit;
	mdss_pkg::cmd_t                   cmd;
	mdss_pkg::status_t                sts;
	logic                             busy;

	// Register decode on the word index
	assign reg_hit = (paddr[mdss_pkg::CFG_ADDR_W-1:2] == mdss_pkg::REG_IDX_DELETIONS);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deletions_q <= '0;
		end else if (psel && penable && pwrite && reg_hit) begin
			deletions_q <= pwdata[mdss_pkg::DELETIONS_W-1:0];
		end
	end

	assign prdata = reg_hit
		? {{(mdss_pkg::CFG_DATA_W - mdss_pkg::DELETIONS_W){1'b0}}, deletions_q}
		: '0;

	mdss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	mdss_dp #(
		.DEQUE_DEPTH   (DEQUE_DEPTH),
		.POSITION_BITS (POSITION_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_word   (in_word),
		.deletions (deletions_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	assign in_stall = busy;

endmodule

// File: sv/mdss_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mdss_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: sv/mdss_ctrl.sv
// Controller state machine of the digit selector: sequences accept, back pops,
// push and emit. Depends on mdss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mdss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  mdss_pkg::status_t sts,
	output mdss_pkg::cmd_t   cmd,
	output logic             busy
);

	mdss_pkg::state_t state_q;
	mdss_pkg::state_t state_nxt;
	logic             st_scan;
	logic             st_wait;
	logic             st_emit;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mdss_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mdss_pkg::S_IDLE: begin
				if (in_valid) state_nxt = mdss_pkg::S_SCAN;
			end
			mdss_pkg::S_SCAN: begin
				if (sts.back_lt) begin
					state_nxt = mdss_pkg::S_BACK_WAIT;
				end else if (sts.emit_hit) begin
					state_nxt = mdss_pkg::S_EMIT;
				end else begin
					state_nxt = mdss_pkg::S_IDLE;
				end
			end
			mdss_pkg::S_BACK_WAIT: begin
				state_nxt = mdss_pkg::S_SCAN;
			end
			mdss_pkg::S_EMIT: begin
				if (sts.out_free) state_nxt = mdss_pkg::S_IDLE;
			end
			default: state_nxt = mdss_pkg::S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			mdss_pkg::S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = in_valid;
			end
			mdss_pkg::S_SCAN: begin
				if (sts.back_lt) begin
					cmd.drop_back = 1'b1;
				end else begin
					cmd.push   = 1'b1;
					cmd.finish = !sts.emit_hit;
				end
			end
			mdss_pkg::S_BACK_WAIT: begin
				cmd.load_back = 1'b1;
			end
			mdss_pkg::S_EMIT: begin
				cmd.emit   = sts.out_free;
				cmd.finish = sts.out_free;
			end
			default: cmd = '0;
		endcase
	end

	// State decodes for the checks below
	assign st_scan = (state_q == mdss_pkg::S_SCAN);
	assign st_wait = (state_q == mdss_pkg::S_BACK_WAIT);
	assign st_emit = (state_q == mdss_pkg::S_EMIT);

	`MDSS_ASSERT_NXT(a_accept_scan, clk, arst_n, cmd.accept, st_scan)
	`MDSS_ASSERT_NXT(a_back_return, clk, arst_n, st_wait, st_scan)
	`MDSS_ASSERT_IMP(a_emit_entry, clk, arst_n, st_emit, $past(st_scan) || $past(st_emit))

endmodule

// File: sv/mdss_dp.sv
// Datapath of the digit selector: circular deque in RAM, counters, window end
// and output register. Depends on mdss_pkg, mdss_ram and assert_macros.svh.
`include "assert_macros.svh"
module mdss_dp #(
	parameter int DEQUE_DEPTH   = mdss_pkg::DEQUE_DEPTH_DEF,
	parameter int POSITION_BITS = mdss_pkg::POSITION_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mdss_pkg::cmd_t                   cmd,
	output mdss_pkg::status_t                sts,
	input  mdss_pkg::in_word_t               in_word,
	input  logic [mdss_pkg::DELETIONS_W-1:0] deletions,
	output logic                             out_valid,
	input  logic                             out_stall,
	output mdss_pkg::out_word_t              out_word
);

	localparam int PTR_W = $clog2(DEQUE_DEPTH);
	localparam int CNT_W = $clog2(DEQUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEQUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEQUE_DEPTH);

	logic [mdss_pkg::DIGIT_W-1:0] digit_q;
	logic                         last_q;
	logic [mdss_pkg::DIGIT_W-1:0] back_q;
	logic                         byp_q;
	logic [PTR_W-1:0]             head_q;
	logic [PTR_W-1:0]             tail_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [POSITION_BITS-1:0]     pos_q;
	logic [POSITION_BITS-1:0]     wend_q;
	logic                         out_valid_q;
	mdss_pkg::out_word_t          out_word_q;

	logic [PTR_W-1:0]             head_inc;
	logic [PTR_W-1:0]             tail_inc;
	logic [PTR_W-1:0]             tail_dec;
	logic [PTR_W-1:0]             tail_dec2;
	logic [PTR_W-1:0]             head_nxt;
	logic                         full;
	logic                         ram_re;
	logic [PTR_W-1:0]             ram_raddr;
	logic [mdss_pkg::DIGIT_W-1:0] ram_rdata;
	logic [mdss_pkg::DIGIT_W-1:0] front_dig;

	// Circular pointer arithmetic (depth need not be a power of two)
	assign head_inc  = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign tail_inc  = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign tail_dec  = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;
	assign tail_dec2 = (tail_dec == '0) ? PTR_LAST : tail_dec - 1'b1;
	assign full      = (cnt_q == CNT_FULL);
	// A push into a full deque drops the front entry first
	assign head_nxt  = full ? head_inc : head_q;

	// Status back to the controller
	assign sts.back_lt  = (cnt_q != '0) && (back_q < digit_q);
	assign sts.emit_hit = (pos_q == wend_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	// Read the new back after a pop, or the front when this push emits
	assign ram_re    = cmd.drop_back || (cmd.push && sts.emit_hit);
	assign ram_raddr = cmd.drop_back ? tail_dec2 : head_nxt;

	mdss_ram #(
		.WIDTH (mdss_pkg::DIGIT_W),
		.DEPTH (DEQUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (tail_q),
		.wdata (digit_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Pushed into an empty deque: the front is the digit itself
	assign front_dig = byp_q ? digit_q : ram_rdata;

	// Item and back-digit holding registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			digit_q <= in_word.digit;
			last_q  <= in_word.last;
		end
		if (cmd.load_back) begin
			back_q <= ram_rdata;
		end else if (cmd.push) begin
			back_q <= digit_q;
			byp_q  <= (cnt_q == '0);
		end
	end

	// Deque pointers, count, position and window end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
			wend_q <= '0;
		end else if (cmd.finish && last_q) begin
			// end of string clears the deque and position and reloads the window end
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
			pos_q  <= '0;
			wend_q <= POSITION_BITS'(deletions);
		end else begin
			if (cmd.accept && (pos_q == '0)) begin
				wend_q <= POSITION_BITS'(deletions);
			end
			if (cmd.drop_back) begin
				tail_q <= tail_dec;
				cnt_q  <= cnt_q - 1'b1;
			end
			if (cmd.push) begin
				tail_q <= tail_inc;
				head_q <= head_nxt;
				if (!full) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				head_q <= head_inc;
				cnt_q  <= cnt_q - 1'b1;
				wend_q <= wend_q + 1'b1;
			end
			if (cmd.finish) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_word_q.kept_digit <= front_dig;
			out_word_q.final_res  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	`MDSS_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_FULL)
	`MDSS_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.drop_back, cnt_q != '0)
	`MDSS_ASSERT_IMP(a_emit_slot, clk, arst_n, cmd.emit, !out_valid_q || !out_stall)

endmodule
